/* sv/skt_pkg.sv */
// Shared types and constants for the sorted top-k table.
package skt_pkg;

	localparam int TABLE_DEPTH = 16;

	localparam int SCORE_W  = 31;
	localparam int BYTE_W   = 8;
	localparam int SLOT_W   = 8;
	localparam int OPC_W    = 2;
	localparam int OUT_CNT_W = 5;
	localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 104;

	typedef enum logic [OPC_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_CHECK  = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [BYTE_W-1:0]  width;
		logic [BYTE_W-1:0]  height;
		logic [BYTE_W-1:0]  speed;
		logic               walls;
		logic               two_p;
	} entry_t;

	// Broadcast to every cell of the chain
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [SLOT_W-1:0] slot;
		entry_t            new_entry;
	} cell_ctrl_t;

	typedef struct packed {
		logic                 accepted;
		logic [OUT_CNT_W-1:0] position;
		logic [OUT_CNT_W-1:0] entry_total;
		logic [SCORE_W-1:0]   top_score;
		entry_t               rd;
	} result_t;

endpackage

/* sv/sorted_top_k_table_unit.sv */
// Top level of the sorted top-k table: request decode, cell chain and result register.
//
//  channel  dir  tdata                                                tuser
//  s_axis   in   score, width, height, speed, walls, 2p, slot index  opcode
//  m_axis   out  accepted, position, total, top score, read entry    -
//
// One request per cycle while no stalled result blocks s_axis: every cell compares
// against the broadcast score and shifts in the same edge, and the result is
// registered and shown on the next cycle. A stalled result holds m_axis and
// s_axis_tready drops only while that result waits and m_axis_tready is low.
// Reset clears every valid bit and the count at once; no clearing pass.
module sorted_top_k_table_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [31:0] score, [39:32] board_width, [47:40] board_height, [55:48] game_speed,
	// [56] walls_on, [57] two_player, [65:58] slot_index, [71:66] zero
	input  logic [skt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [1:0] opcode
	input  logic [skt_pkg::OPC_W-1:0]          s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] accepted, [5:1] position, [10:6] entry_total, [41:11] top_score,
	// [72:42] out_score, [80:73] out_width, [88:81] out_height,
	// [96:89] out_speed, [97] out_walls, [98] out_two_player, [103:99] zero
	output logic [skt_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	localparam int D = skt_pkg::TABLE_DEPTH;

	logic                            req_acc;
	skt_pkg::opcode_t                opc;
	logic [31:0]                     sc_in;
	logic                            sc_pos;
	logic [skt_pkg::SLOT_W-1:0]      slot;
	skt_pkg::cell_ctrl_t             ctrl;

	logic            valid_a [D];
	skt_pkg::entry_t entry_a [D];
	logic            gt_a    [D];
	logic            hit_a   [D];
	logic            nv_a    [D];
	skt_pkg::entry_t ne_a    [D];
	logic            lv_a    [D];
	skt_pkg::entry_t le_a    [D];
	logic            lg_a    [D];
	logic            rv_a    [D];
	skt_pkg::entry_t re_a    [D];

	logic                               any_hit;
	logic                               ins_ok;
	logic                               rem_ok;
	logic [skt_pkg::OUT_CNT_W-1:0]      pos;
	skt_pkg::entry_t                    rd;
	logic [skt_pkg::CNT_W-1:0]          count_q;
	logic [skt_pkg::CNT_W-1:0]          count_nxt;
	logic                               full;

	logic                               out_valid_q;
	skt_pkg::result_t                   res_q;
	skt_pkg::result_t                   res_nxt;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign req_acc       = s_axis_tvalid && s_axis_tready;

	assign opc    = skt_pkg::opcode_t'(s_axis_tuser);
	assign sc_in  = s_axis_tdata[31:0];
	assign sc_pos = !sc_in[31] && (|sc_in[30:0]);
	assign slot   = s_axis_tdata[65:58];

	// Entries are kept descending, so gt is false then true along the chain:
	// the last cell tells whether any slot takes the new score.
	assign ins_ok = req_acc && (opc == skt_pkg::OP_INSERT) && sc_pos && gt_a[D-1];
	assign rem_ok = req_acc && (opc == skt_pkg::OP_REMOVE) && any_hit;

	always_comb begin
		ctrl                     = '0;
		ctrl.ins                 = ins_ok;
		ctrl.rem                 = rem_ok;
		ctrl.slot                = slot;
		ctrl.new_entry.score     = sc_in[30:0];
		ctrl.new_entry.width     = s_axis_tdata[39:32];
		ctrl.new_entry.height    = s_axis_tdata[47:40];
		ctrl.new_entry.speed     = s_axis_tdata[55:48];
		ctrl.new_entry.walls     = s_axis_tdata[56];
		ctrl.new_entry.two_p     = s_axis_tdata[57];
	end

	genvar gi;
	generate
		for (gi = 0; gi < D; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				assign lv_a[gi] = 1'b0;
				assign le_a[gi] = '0;
				assign lg_a[gi] = 1'b0;
			end else begin : g_mid
				assign lv_a[gi] = valid_a[gi-1];
				assign le_a[gi] = entry_a[gi-1];
				assign lg_a[gi] = gt_a[gi-1];
			end
			if (gi == D - 1) begin : g_last
				assign rv_a[gi] = 1'b0;
				assign re_a[gi] = '0;
			end else begin : g_inner
				assign rv_a[gi] = valid_a[gi+1];
				assign re_a[gi] = entry_a[gi+1];
			end

			skt_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.cell_idx    (skt_pkg::SLOT_W'(gi)),
				.left_valid  (lv_a[gi]),
				.left_entry  (le_a[gi]),
				.left_gt     (lg_a[gi]),
				.right_valid (rv_a[gi]),
				.right_entry (re_a[gi]),
				.valid       (valid_a[gi]),
				.entry       (entry_a[gi]),
				.gt          (gt_a[gi]),
				.hit         (hit_a[gi]),
				.nxt_valid   (nv_a[gi]),
				.nxt_entry   (ne_a[gi])
			);
		end
	endgenerate

	// Landing slot and read data: at most one cell matches in each case
	always_comb begin
		pos     = skt_pkg::OUT_CNT_W'(D);
		rd      = '0;
		any_hit = 1'b0;
		for (int i = 0; i < D; i++) begin
			if (gt_a[i] && !lg_a[i]) begin
				pos = skt_pkg::OUT_CNT_W'(i);
			end
			if (hit_a[i]) begin
				any_hit = 1'b1;
				rd      = entry_a[i];
			end
		end
	end

	assign full = (count_q == skt_pkg::CNT_W'(D));

	always_comb begin
		count_nxt = count_q;
		if (ins_ok && !full) begin
			count_nxt = count_q + 1'b1;
		end else if (rem_ok) begin
			count_nxt = count_q - 1'b1;
		end
	end

	always_comb begin
		res_nxt             = '0;
		res_nxt.position    = skt_pkg::OUT_CNT_W'(D);
		res_nxt.entry_total = skt_pkg::OUT_CNT_W'(count_nxt);
		res_nxt.top_score   = nv_a[0] ? ne_a[0].score : '0;
		case (opc)
			skt_pkg::OP_INSERT: begin
				res_nxt.accepted = ins_ok;
				if (ins_ok) begin
					res_nxt.position = pos;
				end
			end
			skt_pkg::OP_REMOVE: begin
				res_nxt.accepted = any_hit;
			end
			skt_pkg::OP_READ: begin
				res_nxt.accepted = any_hit;
				res_nxt.rd       = rd;
			end
			skt_pkg::OP_CHECK: begin
				res_nxt.accepted = sc_pos && gt_a[D-1];
			end
			default: begin
				res_nxt.accepted = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (req_acc) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			res_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0,
		res_q.rd.two_p, res_q.rd.walls, res_q.rd.speed, res_q.rd.height,
		res_q.rd.width, res_q.rd.score, res_q.top_score, res_q.entry_total,
		res_q.position, res_q.accepted};

endmodule

/* sv/skt_cell.sv */
// One slot of the sorted table: holds an entry and shifts with its neighbours.
module skt_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  skt_pkg::cell_ctrl_t       ctrl,
	input  logic [skt_pkg::SLOT_W-1:0] cell_idx,
	input  logic                      left_valid,
	input  skt_pkg::entry_t           left_entry,
	input  logic                      left_gt,
	input  logic                      right_valid,
	input  skt_pkg::entry_t           right_entry,
	output logic                      valid,
	output skt_pkg::entry_t           entry,
	output logic                      gt,
	output logic                      hit,
	output logic                      nxt_valid,
	output skt_pkg::entry_t           nxt_entry
);

	logic            valid_q;
	skt_pkg::entry_t entry_q;

	// Empty slots count as smaller than any new score
	assign gt    = !valid_q || (ctrl.new_entry.score > entry_q.score);
	assign hit   = valid_q && (ctrl.slot == cell_idx);
	assign valid = valid_q;
	assign entry = entry_q;

	always_comb begin
		nxt_valid = valid_q;
		nxt_entry = entry_q;
		if (ctrl.ins) begin
			if (left_gt) begin
				nxt_valid = left_valid;
				nxt_entry = left_entry;
			end else if (gt) begin
				nxt_valid = 1'b1;
				nxt_entry = ctrl.new_entry;
			end
		end
		// close the gap: every slot at or after the removed one pulls from the right
		if (ctrl.rem && (ctrl.slot <= cell_idx)) begin
			nxt_valid = right_valid;
			nxt_entry = right_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= nxt_entry;
	end

endmodule
